>>> src/lpfd_pkg.sv
package lpfd_pkg;

	localparam int BUF_DEPTH_DEF = 128;
	localparam int RUN_LIMIT     = 2;

	localparam logic [3:0] EV_HUNT     = 4'd0;
	localparam logic [3:0] EV_LEN      = 4'd1;
	localparam logic [3:0] EV_PAYLOAD  = 4'd2;
	localparam logic [3:0] EV_TRAIL1   = 4'd3;
	localparam logic [3:0] EV_GOOD     = 4'd4;
	localparam logic [3:0] EV_OVERFLOW = 4'd5;
	localparam logic [3:0] EV_LENDROP  = 4'd6;
	localparam logic [3:0] EV_DOUBLE   = 4'd7;
	localparam logic [3:0] EV_BADTRAIL = 4'd8;
	localparam logic [3:0] EV_RESYNC   = 4'd9;

	typedef struct packed {
		logic [3:0] event_res;
		logic [7:0] payload_byte;
		logic [6:0] byte_index;
		logic [7:0] frame_length;
	} res_t;

endpackage

>>> src/lpfd_rx_if.sv
interface lpfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/lpfd_cfg_if.sv
interface lpfd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] delimiter_byte;

	modport source (output valid, output delimiter_byte, input ready);
	modport sink (input valid, input delimiter_byte, output ready);
endinterface

>>> src/lpfd_res_if.sv
interface lpfd_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_res;
	logic [7:0] payload_byte;
	logic [6:0] byte_index;
	logic [7:0] frame_length;

	modport source (output valid, output event_res, output payload_byte,
		output byte_index, output frame_length, input ready);
	modport sink (input valid, input event_res, input payload_byte,
		input byte_index, input frame_length, output ready);
endinterface

>>> src/lpfd_fsm.sv
module lpfd_fsm #(
	parameter int BUF_DEPTH = lpfd_pkg::BUF_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        delim,
	output lpfd_pkg::res_t    res
);

	localparam int OFFS_W = $clog2(BUF_DEPTH + 1);

	localparam logic [2:0] M_LEN    = 3'd0;
	localparam logic [2:0] M_BODY   = 3'd1;
	localparam logic [2:0] M_TRAIL2 = 3'd2;
	localparam logic [2:0] M_SKIP   = 3'd3;
	localparam logic [2:0] M_HUNT   = 3'd4;

	logic [2:0]        mode_q, mode_n;
	logic [7:0]        len_q, len_n;
	logic [OFFS_W-1:0] fill_q, fill_n;
	logic [1:0]        run_q, run_n, run_inc;
	logic              tfm_q, tfm_n;
	logic              is_delim;

	assign is_delim = (rx_byte == delim);
	assign run_inc  = run_q + 2'd1;

	always_comb begin
		mode_n = mode_q;
		len_n  = len_q;
		fill_n = fill_q;
		run_n  = run_q;
		tfm_n  = tfm_q;
		res    = '0;
		res.event_res = lpfd_pkg::EV_HUNT;
		unique case (mode_q)
			M_SKIP: begin
				mode_n = M_HUNT;
			end
			M_HUNT: begin
				if (is_delim) begin
					if (run_inc >= 2'(lpfd_pkg::RUN_LIMIT)) begin
						mode_n = M_LEN;
						fill_n = '0;
						run_n  = '0;
						tfm_n  = 1'b0;
						res.event_res = lpfd_pkg::EV_RESYNC;
					end else begin
						run_n = run_inc;
					end
				end else begin
					run_n = '0;
				end
			end
			M_TRAIL2: begin
				fill_n = '0;
				run_n  = '0;
				tfm_n  = 1'b0;
				if (tfm_q && is_delim) begin
					mode_n = M_LEN;
					res.event_res    = lpfd_pkg::EV_GOOD;
					res.frame_length = len_q;
				end else begin
					mode_n = M_SKIP;
					res.event_res = lpfd_pkg::EV_BADTRAIL;
				end
			end
			default: begin
				// length byte, payload and first trailer byte
				if (fill_q >= OFFS_W'(BUF_DEPTH)) begin
					mode_n = M_SKIP;
					fill_n = '0;
					run_n  = '0;
					tfm_n  = 1'b0;
					res.event_res = lpfd_pkg::EV_OVERFLOW;
				end else if (mode_q != M_BODY) begin
					len_n  = rx_byte;
					mode_n = M_BODY;
					res.event_res    = lpfd_pkg::EV_LEN;
					res.frame_length = rx_byte;
				end else if ({1'b0, len_q} > 9'(BUF_DEPTH)) begin
					mode_n = M_SKIP;
					fill_n = '0;
					run_n  = '0;
					tfm_n  = 1'b0;
					res.event_res = lpfd_pkg::EV_LENDROP;
				end else if (8'(fill_q) < len_q) begin
					if (is_delim && run_inc >= 2'(lpfd_pkg::RUN_LIMIT)) begin
						mode_n = M_LEN;
						fill_n = '0;
						run_n  = '0;
						tfm_n  = 1'b0;
						res.event_res = lpfd_pkg::EV_DOUBLE;
					end else begin
						run_n  = is_delim ? run_inc : 2'd0;
						fill_n = fill_q + OFFS_W'(1);
						res.event_res    = lpfd_pkg::EV_PAYLOAD;
						res.payload_byte = rx_byte;
						res.byte_index   = 7'(fill_q);
					end
				end else begin
					tfm_n  = is_delim;
					mode_n = M_TRAIL2;
					res.event_res = lpfd_pkg::EV_TRAIL1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_LEN;
			len_q  <= '0;
			fill_q <= '0;
			run_q  <= '0;
			tfm_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_n;
			len_q  <= len_n;
			fill_q <= fill_n;
			run_q  <= run_n;
			tfm_q  <= tfm_n;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= OFFS_W'(BUF_DEPTH))
		else $error("fill offset beyond buffer depth");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q < 2'(lpfd_pkg::RUN_LIMIT))
		else $error("delimiter run reached limit without restart");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_LEN || mode_q == M_SKIP) |-> (fill_q == '0 && !tfm_q))
		else $error("offset or trailer match left set outside a frame");

	a_skip_once: assert property (@(posedge clk) disable iff (!arst_n)
		(step && mode_q == M_SKIP) |=> (mode_q == M_HUNT))
		else $error("skip did not move to hunt");

endmodule

>>> src/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer with a two-byte delimiter trailer.
// rx: received bytes, one transaction per byte (valid/ready).
// res: one transaction per received byte carrying the event code, payload byte
//   with its frame index, and the declared frame length.
// cfg: write-only channel for the delimiter byte; always ready. Write it only
//   while no byte is in flight.
// A byte accepted on rx is held in the input register, then decoded into the
// result register, from which it is offered on res.
// Throughput: one byte per cycle while res does not stall; the frame state
// machine decides each byte combinationally between input and result registers.
// When res stalls, the result register holds, the input register still takes
// one more byte, and rx.ready drops until res moves again.
// Reset: frame state returns to waiting for a length byte, delimiter is 0,
// both pipeline registers are empty.
module length_prefixed_frame_deframer #(
	parameter int BUF_DEPTH = lpfd_pkg::BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lpfd_rx_if.sink    rx,
	lpfd_cfg_if.sink   cfg,
	lpfd_res_if.source res
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           out_valid_q;
	lpfd_pkg::res_t out_q;
	lpfd_pkg::res_t step_res;
	logic [7:0]     delim_q;
	logic           advance;

	assign advance  = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= '0;
		end else if (cfg.valid) begin
			delim_q <= cfg.delimiter_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	lpfd_fsm #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.delim   (delim_q),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.event_res    = out_q.event_res;
	assign res.payload_byte = out_q.payload_byte;
	assign res.byte_index   = out_q.byte_index;
	assign res.frame_length = out_q.frame_length;

endmodule
